### rtl/core/esf_pkg.sv
// shared types and constants for the encoder speed filter
package esf_pkg;

  localparam int unsigned CFG_DATA_BITS  = 31;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned MUL_BITS       = 33;
  localparam int unsigned PROD_BITS      = 2 * MUL_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENCODER_COUNTS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_GAIN     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_KEEP    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_TAKE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RPM_FULL_SCALE = 3'd4;

  localparam logic [24:0] RST_ENCODER_COUNTS = 25'd131072;
  localparam logic [24:0] RST_COUNT_GAIN     = 25'd128;
  localparam logic [24:0] RST_FILTER_KEEP    = 25'd16441671;
  localparam logic [24:0] RST_FILTER_TAKE    = 25'd335544;
  localparam logic [30:0] RST_RPM_FULL_SCALE = 31'd30000000;

  localparam logic signed [31:0] Q24_ONE     = 32'sd16777216;
  localparam logic signed [31:0] Q24_NEG_ONE = -32'sd16777216;

  typedef struct packed {
    logic load;
    logic step;
  } wrap_ctl_t;

endpackage

### rtl/core/esf_mul.sv
// shared signed multiplier with registered product
module esf_mul (
  input  logic                                    clk,
  input  logic signed [esf_pkg::MUL_BITS-1:0]     a,
  input  logic signed [esf_pkg::MUL_BITS-1:0]     b,
  output logic signed [esf_pkg::PROD_BITS-1:0]    prod_r
);
  import esf_pkg::*;

  logic signed [PROD_BITS-1:0] prod_nxt;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

### rtl/core/esf_wrap.sv
// position difference and half-revolution wrap
module esf_wrap #(
  parameter int POSITION_BITS = 24,
  parameter int DELTA_BITS    = 27
) (
  input  logic                          clk,
  input  esf_pkg::wrap_ctl_t            ctl,
  input  logic [POSITION_BITS-1:0]      position,
  input  logic [POSITION_BITS-1:0]      last_position,
  input  logic [24:0]                   encoder_counts,
  output logic signed [DELTA_BITS-1:0]  delta_r
);
  import esf_pkg::*;

  logic signed [DELTA_BITS-1:0] diff_r;
  logic signed [DELTA_BITS-1:0] diff_nxt;
  logic signed [DELTA_BITS-1:0] counts_s;
  logic signed [DELTA_BITS-1:0] half_s;
  logic signed [DELTA_BITS-1:0] delta_nxt;
  logic                         above;
  logic                         below;

  assign diff_nxt = $signed({{(DELTA_BITS-POSITION_BITS){1'b0}}, position})
                  - $signed({{(DELTA_BITS-POSITION_BITS){1'b0}}, last_position});
  assign counts_s = $signed({{(DELTA_BITS-25){1'b0}}, encoder_counts});
  assign half_s   = $signed({{(DELTA_BITS-24){1'b0}}, encoder_counts[24:1]});
  assign above    = diff_r > half_s;
  assign below    = diff_r < -half_s;

  always_comb begin
    if (above) begin
      delta_nxt = diff_r - counts_s;
    end else if (below) begin
      delta_nxt = diff_r + counts_s;
    end else begin
      delta_nxt = diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      diff_r <= diff_nxt;
    end
    if (ctl.step) begin
      delta_r <= delta_nxt;
    end
  end

endmodule

### rtl/core/encoder_speed_filter_unit.sv
// encoder speed estimator top level: sequencer, state and output register
//
// Input channel: in_valid/in_stall carry one request, either a position
// sample (in_operation 0) or an external Q24 speed (in_operation 1).
// Result channel: out_valid/out_stall carry the wrapped count difference,
// the clamped Q24 filter value and the speed in 0.0001 rpm.
// Each request walks a sequencer through wrap, scale, two filter products,
// a sum and the rpm product, all on one shared 33x33 multiplier with a
// registered product. The result is registered in the output register
// after the last step, and in_stall is high until the sequencer is back
// in idle, so a new request is taken only once the last one is through.
// A finished result waits in the output register while the next request
// is already taken; if the receiver still stalls at the end of that next
// request, the sequencer waits in its last step until the register frees.
// Configuration writes are registered directly and must be made while idle.
// Synchronous reset loads the register defaults, clears the previous
// position, filter value and held speed, and empties the output register.
module encoder_speed_filter_unit #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [esf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [esf_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_operation,
  input  logic [POSITION_BITS-1:0]               in_position,
  input  logic                                   in_encoder_error,
  input  logic signed [31:0]                     in_external_speed,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [24:0]                     out_position_delta,
  output logic signed [25:0]                     out_filtered_speed,
  output logic signed [31:0]                     out_motor_rpm
);
  import esf_pkg::*;

  localparam int DELTA_BITS = ((POSITION_BITS > 25) ? POSITION_BITS : 25) + 2;
  localparam int WIDE_BITS  = (DELTA_BITS > MUL_BITS) ? DELTA_BITS : MUL_BITS;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_WRAP  = 8'b0000_0010,
    ST_SCALE = 8'b0000_0100,
    ST_KEEP  = 8'b0000_1000,
    ST_TAKE  = 8'b0001_0000,
    ST_SUM   = 8'b0010_0000,
    ST_RPM   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [24:0]                  encoder_counts_r;
  logic [24:0]                  count_gain_r;
  logic [24:0]                  filter_keep_r;
  logic [24:0]                  filter_take_r;
  logic [30:0]                  rpm_full_scale_r;

  logic [POSITION_BITS-1:0]     last_position_r;
  logic signed [31:0]           filter_value_r;
  logic signed [31:0]           held_speed_r;

  logic                         op_r;
  logic                         err_r;
  logic signed [31:0]           ext_r;
  logic signed [31:0]           speed_r;
  logic signed [31:0]           acc_r;
  logic signed [31:0]           raw_r;

  logic                         out_valid_r;
  logic signed [24:0]           out_delta_r;
  logic signed [25:0]           out_filt_r;
  logic signed [31:0]           out_rpm_r;

  wrap_ctl_t                    wrap_ctl;
  logic signed [DELTA_BITS-1:0] delta_r;
  logic signed [WIDE_BITS-1:0]  delta_w;
  logic signed [MUL_BITS-1:0]   delta_c;
  logic signed [24:0]           delta_out;

  logic signed [MUL_BITS-1:0]   mul_a;
  logic signed [MUL_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]  prod_r;
  logic signed [31:0]           prod_q24;
  logic signed [31:0]           prod_sat;
  logic signed [31:0]           scaled_speed;
  logic signed [31:0]           raw_clamp;

  logic                         in_take;
  logic                         out_free;

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encoder_counts_r <= RST_ENCODER_COUNTS;
      count_gain_r     <= RST_COUNT_GAIN;
      filter_keep_r    <= RST_FILTER_KEEP;
      filter_take_r    <= RST_FILTER_TAKE;
      rpm_full_scale_r <= RST_RPM_FULL_SCALE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENCODER_COUNTS: encoder_counts_r <= cfg_data[24:0];
        REG_COUNT_GAIN:     count_gain_r     <= cfg_data[24:0];
        REG_FILTER_KEEP:    filter_keep_r    <= cfg_data[24:0];
        REG_FILTER_TAKE:    filter_take_r    <= cfg_data[24:0];
        REG_RPM_FULL_SCALE: rpm_full_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // wrap unit
  assign wrap_ctl.load = in_take;
  assign wrap_ctl.step = (state_r == ST_WRAP);

  esf_wrap #(
    .POSITION_BITS (POSITION_BITS),
    .DELTA_BITS    (DELTA_BITS)
  ) u_wrap (
    .clk            (clk),
    .ctl            (wrap_ctl),
    .position       (in_position),
    .last_position  (last_position_r),
    .encoder_counts (encoder_counts_r),
    .delta_r        (delta_r)
  );

  // clamp of the difference for the multiplier and for the output field
  assign delta_w = WIDE_BITS'(delta_r);

  always_comb begin
    if (delta_w[WIDE_BITS-1:MUL_BITS-1] == {(WIDE_BITS-MUL_BITS+1){delta_w[WIDE_BITS-1]}}) begin
      delta_c = delta_w[MUL_BITS-1:0];
    end else begin
      delta_c = {delta_w[WIDE_BITS-1], {(MUL_BITS-1){~delta_w[WIDE_BITS-1]}}};
    end
    if (delta_w[WIDE_BITS-1:24] == {(WIDE_BITS-24){delta_w[WIDE_BITS-1]}}) begin
      delta_out = delta_w[24:0];
    end else begin
      delta_out = {delta_w[WIDE_BITS-1], {24{~delta_w[WIDE_BITS-1]}}};
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r) inside
      ST_SCALE: begin
        mul_a = delta_c;
        mul_b = $signed({8'd0, count_gain_r});
      end
      ST_KEEP: begin
        mul_a = MUL_BITS'(filter_value_r);
        mul_b = $signed({8'd0, filter_keep_r});
      end
      ST_TAKE: begin
        mul_a = MUL_BITS'(speed_r);
        mul_b = $signed({8'd0, filter_take_r});
      end
      // rpm product held while the result waits
      ST_RPM, ST_FIN: begin
        mul_a = MUL_BITS'(raw_r);
        mul_b = $signed({2'd0, rpm_full_scale_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  esf_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign prod_q24 = prod_r[55:24];

  always_comb begin
    if (prod_r[PROD_BITS-1:31] == {(PROD_BITS-31){prod_r[PROD_BITS-1]}}) begin
      prod_sat = prod_r[31:0];
    end else begin
      prod_sat = {prod_r[PROD_BITS-1], {31{~prod_r[PROD_BITS-1]}}};
    end
    if (op_r) begin
      scaled_speed = ext_r;
    end else if (err_r) begin
      scaled_speed = held_speed_r;
    end else begin
      scaled_speed = prod_sat;
    end
    if (raw_r > Q24_ONE) begin
      raw_clamp = Q24_ONE;
    end else if (raw_r < Q24_NEG_ONE) begin
      raw_clamp = Q24_NEG_ONE;
    end else begin
      raw_clamp = raw_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_WRAP;
      ST_WRAP:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_KEEP;
      ST_KEEP:  state_nxt = ST_TAKE;
      ST_TAKE:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_RPM;
      ST_RPM:   state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      last_position_r <= '0;
      filter_value_r  <= '0;
      held_speed_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take && !in_operation) begin
        last_position_r <= in_position;
      end
      if ((state_r == ST_KEEP) && !op_r && !err_r) begin
        held_speed_r <= prod_sat;
      end
      if ((state_r == ST_FIN) && out_free) begin
        filter_value_r <= raw_clamp;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r  <= in_operation;
      err_r <= in_encoder_error;
      ext_r <= in_external_speed;
    end
    if (state_r == ST_KEEP) begin
      speed_r <= scaled_speed;
    end
    if (state_r == ST_TAKE) begin
      acc_r <= prod_q24;
    end
    if (state_r == ST_SUM) begin
      raw_r <= acc_r + prod_q24;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_delta_r <= op_r ? 25'sd0 : delta_out;
      out_filt_r  <= raw_clamp[25:0];
      out_rpm_r   <= prod_q24;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position_delta = out_delta_r;
  assign out_filtered_speed = out_filt_r;
  assign out_motor_rpm      = out_rpm_r;

endmodule

### sim/esf_test_pkg.sv
// operation codes shared by the encoder speed filter testbench files
package esf_test_pkg;

  localparam logic OP_POSITION = 1'b0;
  localparam logic OP_EXTERNAL = 1'b1;

endpackage

### sim/esf_checker.sv
// checker for the encoder speed filter: predicts every result and compares it field by field
module esf_checker #(
  parameter int POSITION_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [esf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [esf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_operation,
  input  logic [POSITION_BITS-1:0]           in_position,
  input  logic                               in_encoder_error,
  input  logic signed [31:0]                 in_external_speed,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [24:0]                 out_position_delta,
  input  logic signed [25:0]                 out_filtered_speed,
  input  logic signed [31:0]                 out_motor_rpm,
  output int                                 pending,
  output int                                 fail_count
);
  import esf_pkg::*;
  import esf_test_pkg::*;

  localparam longint SCALED_MIN = -64'sd2147483648;
  localparam longint SCALED_MAX = 64'sd2147483647;

  typedef struct packed {
    logic signed [24:0] delta;
    logic signed [25:0] speed;
    logic signed [31:0] rpm;
  } speed_sample_t;

  speed_sample_t speed_q[$];

  logic [24:0]              counts_cfg;
  logic [24:0]              gain_cfg;
  logic [24:0]              keep_cfg;
  logic [24:0]              take_cfg;
  logic [30:0]              rpm_cfg;
  logic [POSITION_BITS-1:0] prev_position;
  logic signed [31:0]       filter_acc;
  logic signed [31:0]       held_scaled;

  int queued     = 0;
  int mismatches = 0;

  assign pending    = queued;
  assign fail_count = mismatches;

  // full product, floor shift by 24, low 32 bits kept
  function automatic logic signed [31:0] q24_mul(longint a, longint b);
    logic signed [63:0] p;
    p = a * b;
    return p[55:24];
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic speed_sample_t filter_request(logic op, logic [POSITION_BITS-1:0] pos,
                                                   logic err, logic signed [31:0] ext);
    speed_sample_t      r;
    longint             diff;
    longint             half;
    longint             counts;
    longint             gain;
    longint             scaled;
    longint             limited;
    logic signed [31:0] raw;
    diff = 0;
    if (op == OP_POSITION) begin
      counts = longint'(counts_cfg);
      half   = longint'(counts_cfg) >> 1;
      gain   = longint'(gain_cfg);
      diff   = longint'(pos) - longint'(prev_position);
      if (diff > half) diff -= counts;
      if (diff < -half) diff += counts;
      if (!err) begin
        scaled      = clamp(diff * gain, SCALED_MIN, SCALED_MAX);
        held_scaled = scaled[31:0];
      end else begin
        scaled = longint'(held_scaled);
      end
      prev_position = pos;
    end else begin
      scaled = longint'(ext);
    end
    raw        = q24_mul(longint'(keep_cfg), longint'(filter_acc))
               + q24_mul(longint'(take_cfg), scaled);
    r.rpm      = q24_mul(longint'(rpm_cfg), longint'(raw));
    limited    = clamp(longint'(raw), longint'(Q24_NEG_ONE), longint'(Q24_ONE));
    filter_acc = limited[31:0];
    r.speed    = limited[25:0];
    limited    = clamp(diff, longint'(Q24_NEG_ONE), longint'(Q24_ONE) - 1);
    r.delta    = limited[24:0];
    return r;
  endfunction

  always @(posedge clk) begin
    speed_sample_t want;
    if (!rst_n) begin
      counts_cfg    = RST_ENCODER_COUNTS;
      gain_cfg      = RST_COUNT_GAIN;
      keep_cfg      = RST_FILTER_KEEP;
      take_cfg      = RST_FILTER_TAKE;
      rpm_cfg       = RST_RPM_FULL_SCALE;
      prev_position = '0;
      filter_acc    = '0;
      held_scaled   = '0;
      speed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (speed_q.size() == 0) begin
          $error("result with no request waiting: position_delta %0d", out_position_delta);
          mismatches++;
        end else begin
          want = speed_q.pop_front();
          if (out_position_delta !== want.delta) begin
            $error("position_delta mismatch: expected %0d, actual %0d",
                   want.delta, out_position_delta);
            mismatches++;
          end
          if (out_filtered_speed !== want.speed) begin
            $error("filtered_speed mismatch: expected %0d, actual %0d",
                   want.speed, out_filtered_speed);
            mismatches++;
          end
          if (out_motor_rpm !== want.rpm) begin
            $error("motor_rpm mismatch: expected %0d, actual %0d", want.rpm, out_motor_rpm);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ENCODER_COUNTS: counts_cfg = cfg_data[24:0];
          REG_COUNT_GAIN:     gain_cfg   = cfg_data[24:0];
          REG_FILTER_KEEP:    keep_cfg   = cfg_data[24:0];
          REG_FILTER_TAKE:    take_cfg   = cfg_data[24:0];
          REG_RPM_FULL_SCALE: rpm_cfg    = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        speed_q.push_back(filter_request(in_operation, in_position, in_encoder_error,
                                         in_external_speed));
    end
    queued = speed_q.size();
  end

endmodule

### sim/encoder_speed_filter_unit_test.sv
// testbench top for the encoder speed filter: stimulus, receiver stalls and verdict
module encoder_speed_filter_unit_test;
  import esf_pkg::*;
  import esf_test_pkg::*;

  localparam int POSITION_BITS = 24;

  logic                          clk               = 1'b0;
  logic                          rst_n             = 1'b0;
  logic                          cfg_wr_en         = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index         = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data          = '0;
  logic                          in_valid          = 1'b0;
  logic                          in_operation      = 1'b0;
  logic [POSITION_BITS-1:0]      in_position       = '0;
  logic                          in_encoder_error  = 1'b0;
  logic signed [31:0]            in_external_speed = '0;
  logic                          out_stall         = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic signed [24:0]            out_position_delta;
  logic signed [25:0]            out_filtered_speed;
  logic signed [31:0]            out_motor_rpm;
  int                            pending;
  int                            fail_count;

  int unsigned                   hold_off_req  = 0;
  int unsigned                   hold_off_seen = 0;
  bit                            holding       = 1'b0;
  logic [POSITION_BITS-1:0]      stim_pos      = '0;

  encoder_speed_filter_unit #(.POSITION_BITS(POSITION_BITS)) uut (.*);

  esf_checker #(.POSITION_BITS(POSITION_BITS)) speed_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: runs of random stall modes, long hold-off on request
  initial begin
    int mode;
    int run_len;
    forever begin
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen = hold_off_req;
        holding = 1'b1;
        repeat (400) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        holding = 1'b0;
      end else begin
        mode    = $urandom_range(0, 3);
        run_len = $urandom_range(20, 150);
        while (run_len > 0 && hold_off_req == hold_off_seen) begin
          @(negedge clk);
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= ($urandom_range(0, 9) == 0);
          endcase
          run_len--;
        end
      end
    end
  end

  task automatic offer(input logic op, input logic [POSITION_BITS-1:0] pos, input logic err,
                       input logic signed [31:0] ext);
    @(negedge clk);
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_position       <= pos;
    in_encoder_error  <= err;
    in_external_speed <= ext;
    if (op == OP_POSITION) stim_pos = pos;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // wait out every request in flight, then the block's latency
  task automatic drain();
    pause(1);
    wait (pending == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [30:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(input logic [30:0] counts, input logic [30:0] gain,
                                input logic [30:0] keep, input logic [30:0] take,
                                input logic [30:0] rpm);
    drain();
    set_reg(REG_ENCODER_COUNTS, counts);
    set_reg(REG_COUNT_GAIN, gain);
    set_reg(REG_FILTER_KEEP, keep);
    set_reg(REG_FILTER_TAKE, take);
    set_reg(REG_RPM_FULL_SCALE, rpm);
  endtask

  task automatic random_settings();
    logic [30:0] counts;
    logic [30:0] gain;
    logic [30:0] keep;
    logic [30:0] take;
    logic [30:0] rpm;
    case ($urandom_range(0, 3))
      0:       counts = 31'(RST_ENCODER_COUNTS);
      1:       counts = 31'(Q24_ONE);
      2:       counts = 31'($urandom_range(2, Q24_ONE));
      default: counts = 31'($urandom_range(0, 2 * Q24_ONE - 1));
    endcase
    gain = 31'(($urandom_range(0, 3) == 0) ? $urandom_range(0, Q24_ONE)
                                           : $urandom_range(0, 4096));
    keep = 31'($urandom_range(0, Q24_ONE));
    take = 31'($urandom_range(0, 1) ? Q24_ONE - keep : $urandom_range(0, Q24_ONE));
    rpm  = 31'($urandom_range(0, 1) ? RST_RPM_FULL_SCALE : $urandom());
    apply_settings(counts, gain, keep, take, rpm);
    if ($urandom_range(0, 1))
      set_reg(CFG_INDEX_BITS'($urandom_range(REG_RPM_FULL_SCALE + 1,
                                             (1 << CFG_INDEX_BITS) - 1)),
              31'($urandom()));
  endtask

  // mostly plausible position tracks, some external speed, some noise
  task automatic random_request();
    int                       pick;
    int                       step;
    int                       sum;
    logic [POSITION_BITS-1:0] pos;
    logic signed [31:0]       ext;
    pick = $urandom_range(0, 99);
    pos  = POSITION_BITS'($urandom());
    ext  = $urandom();
    if (pick < 70) begin
      case ($urandom_range(0, 3))
        0:       step = $urandom_range(0, 128) - 64;
        1:       step = $urandom_range(0, 8192) - 4096;
        2:       step = $urandom_range(0, 262144) - 131072;
        default: step = $urandom();
      endcase
      sum = stim_pos + step;
      offer(OP_POSITION, sum[POSITION_BITS-1:0], $urandom_range(0, 9) == 0, ext);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) ext = $urandom_range(0, 2 * Q24_ONE) - Q24_ONE;
      offer(OP_EXTERNAL, pos, $urandom_range(0, 1) == 1, ext);
    end else begin
      offer(OP_POSITION, pos, $urandom_range(0, 1) == 1, ext);
    end
  endtask

  initial begin
    int phase;
    int i;
    int burst;
    int idx;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default settings: wrap boundaries, error hold, external extremes
    offer(OP_POSITION, 24'd0, 1'b0, '0);
    offer(OP_POSITION, 24'd65536, 1'b0, '0);
    offer(OP_POSITION, 24'd0, 1'b0, '0);
    offer(OP_POSITION, 24'd65537, 1'b0, '0);
    offer(OP_POSITION, 24'd0, 1'b0, '0);
    offer(OP_POSITION, 24'hFFFFFF, 1'b0, '0);
    offer(OP_POSITION, 24'd0, 1'b1, '0);
    offer(OP_POSITION, 24'd200, 1'b0, '0);
    offer(OP_EXTERNAL, 24'hABCDEF, 1'b1, 32'sh7FFFFFFF);
    offer(OP_EXTERNAL, 24'h543210, 1'b0, 32'sh80000000);
    offer(OP_EXTERNAL, 24'd0, 1'b0, Q24_ONE);
    offer(OP_EXTERNAL, 24'd0, 1'b0, Q24_NEG_ONE);
    offer(OP_POSITION, 24'd300, 1'b0, '0);

    apply_settings(31'd2, 31'(Q24_ONE), 31'd0, 31'(Q24_ONE), 31'h7FFFFFFF);
    offer(OP_POSITION, 24'hFFFFFF, 1'b0, '0);
    offer(OP_POSITION, 24'd0, 1'b0, '0);
    offer(OP_EXTERNAL, 24'd0, 1'b0, 32'sh7FFFFFFF);
    offer(OP_EXTERNAL, 24'd0, 1'b0, 32'sh80000000);

    apply_settings(31'(Q24_ONE), 31'd0, 31'(Q24_ONE), 31'd0, 31'd0);
    offer(OP_POSITION, 24'hFFFFFF, 1'b0, '0);
    offer(OP_POSITION, 24'h800000, 1'b0, '0);
    offer(OP_EXTERNAL, 24'd0, 1'b0, 32'sh7FFFFFFF);

    // degenerate and full-width register values, unknown indexes
    apply_settings(31'd0, 31'h1FFFFFF, 31'h1FFFFFF, 31'h1FFFFFF, 31'h7FFFFFFF);
    for (idx = REG_RPM_FULL_SCALE + 1; idx < (1 << CFG_INDEX_BITS); idx++)
      set_reg(CFG_INDEX_BITS'(idx), 31'($urandom()));
    offer(OP_POSITION, 24'd5, 1'b0, '0);
    offer(OP_POSITION, 24'd0, 1'b0, '0);
    apply_settings(31'd1, 31'(RST_COUNT_GAIN), 31'(RST_FILTER_KEEP), 31'(RST_FILTER_TAKE),
                   RST_RPM_FULL_SCALE);
    offer(OP_POSITION, 24'hFFFFFF, 1'b0, '0);
    offer(OP_POSITION, 24'd0, 1'b0, '0);

    for (phase = 0; phase < 6; phase++) begin
      random_settings();
      burst = 0;
      for (i = 0; i < 216; i++) begin
        if (i == 60 && phase % 2 == 1) begin
          // receiver holds off while requests keep coming
          pause(1);
          hold_off_req++;
          wait (holding);
          repeat (30) random_request();
        end
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0: begin
              pause(1);
              wait (pending == 0);
            end
            1, 2, 3: ;
            default: pause($urandom_range(1, 12));
          endcase
        end
        random_request();
        burst--;
      end
    end

    drain();
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/esf_pkg.sv
rtl/core/esf_mul.sv
rtl/core/esf_wrap.sv
rtl/core/encoder_speed_filter_unit.sv
sim/esf_test_pkg.sv
sim/esf_checker.sv
sim/encoder_speed_filter_unit_test.sv
